@@ rtl/core/pcm_to_pwm_level_formatter_core_defines.svh @@
// ----------------------------------------------------------------------------
// PWM level formatter assertion macros
// Shared property templates for the checker.
// ----------------------------------------------------------------------------
`ifndef PCM_TO_PWM_LEVEL_FORMATTER_CORE_DEFINES_SVH
`define PCM_TO_PWM_LEVEL_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define PWMF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pwmf check failed");

// Next-cycle implication, masked while reset is low.
`define PWMF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pwmf check failed");

// Next-cycle implication that also runs through reset.
`define PWMF_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pwmf check failed");

`endif

@@ rtl/core/pwmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM level formatter package
// Types, register indexes and constants shared by the formatter modules.
// ----------------------------------------------------------------------------
package pwmf_pkg;

    localparam int MAX_COPY_SHIFT = 3;
    localparam int SHIFT_W        = $clog2(MAX_COPY_SHIFT + 1);
    localparam int CNT_W          = MAX_COPY_SHIFT;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int SAMPLE_W = 16;
    localparam int VOLUME_W = 9;
    localparam int LEVEL_W  = 12;
    localparam int PROD_W   = SAMPLE_W + VOLUME_W;
    localparam int LEVEL_SHIFT  = 4;
    localparam int LEVEL_OFFSET = 32'h8000;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = VOLUME_W;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_Q8     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COPY_SHIFT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_STEREO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_STEREO = 2'd3;

    localparam logic [VOLUME_W-1:0] VOLUME_RESET = 9'd205;
    localparam logic [1:0]          REPEAT_RESET = 2'd1;

    typedef struct packed {
        logic [VOLUME_W-1:0] volume_q8;
        logic [1:0]          copy_shift;
        logic                source_stereo;
        logic                output_stereo;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] right_level;
        logic               last_repeat;
    } t_out_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] right_level;
        logic [CNT_W-1:0]   last_idx;
    } t_q_entry;

    typedef struct packed {
        logic     vld;
        t_q_entry data;
    } t_q_head;

endpackage

@@ rtl/core/pcm_to_pwm_level_formatter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM to PWM level formatter
// Turns signed audio frames into repeated 12-bit PWM level pairs.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        sink       i_in_valid/o_in_ready   t_in_item  (left, right sample)
//  out       source     o_out_valid/i_out_ready t_out_item (levels, last copy)
//  cfg       sink       i_cfg_we                i_cfg_idx, i_cfg_data
//
//  A frame's products are registered at its transfer (multiply), its levels are
//  formed from them (level) and written to the queue when it has room, and each
//  copy is offered from the output register. The repeat stage sends one copy per
//  cycle while the output is not stalled, 2^copy_shift copies per frame.
//  A two-entry queue lets the front keep taking frames while output stalls.
//  Reset is synchronous and restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module pcm_to_pwm_level_formatter_core import pwmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_cfg     r_cfg;
    logic     w_push;
    logic     w_push_ready;
    t_q_entry w_push_data;
    t_q_head  w_head;
    logic     w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volume_q8     <= VOLUME_RESET;
            r_cfg.copy_shift    <= REPEAT_RESET;
            r_cfg.source_stereo <= 1'b0;
            r_cfg.output_stereo <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VOLUME_Q8:     r_cfg.volume_q8     <= i_cfg_data;
                CFG_COPY_SHIFT:    r_cfg.copy_shift    <= i_cfg_data[1:0];
                CFG_SOURCE_STEREO: r_cfg.source_stereo <= i_cfg_data[0];
                CFG_OUTPUT_STEREO: r_cfg.output_stereo <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pwmf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    pwmf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    pwmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/core/pwmf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM level formatter front end
// Scales each frame by the volume, forms the 12-bit levels and queues them.
// ----------------------------------------------------------------------------
module pwmf_front import pwmf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_data,
    output logic     o_push,
    input  logic     i_push_ready,
    output t_q_entry o_push_data
);

    logic                     r_s1_vld;
    logic signed [PROD_W-1:0] r_prod_l;
    logic signed [PROD_W-1:0] r_prod_r;
    logic [CNT_W-1:0]         r_last_idx;
    logic                     r_avg;

    logic signed [PROD_W:0]     w_mul_l;
    logic signed [PROD_W:0]     w_mul_r;
    logic signed [SAMPLE_W-1:0] w_right_src;
    logic [SHIFT_W-1:0]         w_shift;
    logic [CNT_W:0]             w_copies;
    logic [CNT_W-1:0]           w_last_idx;
    logic                       w_load;
    logic [LEVEL_W-1:0]         w_lvl_l;
    logic [LEVEL_W-1:0]         w_lvl_r;
    logic [LEVEL_W:0]           w_sum;

    // Truncating divide by 256, offset, clamp to 16 bits, keep the top 12.
    function automatic logic [LEVEL_W-1:0] to_level(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0]   biased;
        logic signed [PROD_W-9:0]   scaled;
        logic signed [PROD_W-7:0]   off;
        logic [LEVEL_W-1:0]         lvl;
        biased = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
        scaled = biased[PROD_W-1:8];
        off    = (PROD_W-6)'(scaled) + (PROD_W-6)'(LEVEL_OFFSET);
        if (off[PROD_W-7]) begin
            lvl = '0;
        end else if (off[LEVEL_W+LEVEL_SHIFT]) begin
            lvl = '1;
        end else begin
            lvl = off[LEVEL_W+LEVEL_SHIFT-1:LEVEL_SHIFT];
        end
        return lvl;
    endfunction

    assign o_in_ready  = !r_s1_vld || i_push_ready;
    assign w_load      = i_in_valid && o_in_ready;
    assign w_right_src = i_cfg.source_stereo ? i_in_data.right_sample : i_in_data.left_sample;
    assign w_mul_l     = i_in_data.left_sample * $signed({1'b0, i_cfg.volume_q8});
    assign w_mul_r     = w_right_src * $signed({1'b0, i_cfg.volume_q8});

    assign w_shift    = (32'(i_cfg.copy_shift) > MAX_COPY_SHIFT) ?
                        SHIFT_W'(MAX_COPY_SHIFT) : SHIFT_W'(i_cfg.copy_shift);
    assign w_copies   = (CNT_W+1)'(1) << w_shift;
    assign w_last_idx = CNT_W'(w_copies - (CNT_W+1)'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_load) begin
            r_s1_vld <= 1'b1;
        end else if (i_push_ready) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_prod_l   <= w_mul_l[PROD_W-1:0];
            r_prod_r   <= w_mul_r[PROD_W-1:0];
            r_last_idx <= w_last_idx;
            r_avg      <= !i_cfg.output_stereo;
        end
    end

    always_comb begin
        w_lvl_l = to_level(r_prod_l);
        w_lvl_r = to_level(r_prod_r);
        w_sum   = {1'b0, w_lvl_l} + {1'b0, w_lvl_r};
        o_push_data.last_idx = r_last_idx;
        if (r_avg) begin
            o_push_data.left_level  = w_sum[LEVEL_W:1];
            o_push_data.right_level = w_sum[LEVEL_W:1];
        end else begin
            o_push_data.left_level  = w_lvl_l;
            o_push_data.right_level = w_lvl_r;
        end
    end

    assign o_push = r_s1_vld;

endmodule

@@ rtl/core/pwmf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM level formatter frame queue
// Short register queue between the front end and the repeat stage.
// ----------------------------------------------------------------------------
module pwmf_queue import pwmf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_push_ready,
    input  t_q_entry i_push_data,
    output t_q_head  o_head,
    input  logic     i_pop
);

    t_q_entry           r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_head.vld;
    assign o_head.vld   = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/core/pwmf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM level formatter repeat stage
// Emits each queued level pair the configured number of times.
// ----------------------------------------------------------------------------
module pwmf_back import pwmf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_head   i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [CNT_W-1:0] r_cnt;
    logic             r_out_vld;
    t_out_item        r_out;
    logic             w_emit;
    logic             w_last;

    assign w_emit = i_head.vld && (!r_out_vld || i_out_ready);
    assign w_last = (r_cnt == i_head.data.last_idx);
    // Release the queue entry with its final copy.
    assign o_pop  = w_emit && w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
            r_cnt     <= w_last ? '0 : r_cnt + 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.left_level  <= i_head.data.left_level;
            r_out.right_level <= i_head.data.right_level;
            r_out.last_repeat <= w_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/pwmf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM level formatter checker
// Port-level properties of the formatter, attached by bind.
// ----------------------------------------------------------------------------
`include "pcm_to_pwm_level_formatter_core_defines.svh"

module pwmf_checker import pwmf_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // Hold a stalled result.
    `PWMF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // A copy that is not the last is followed at once by another of the same frame.
    `PWMF_ASSERT_NXT(a_repeat_run, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_data.last_repeat, o_out_valid && $stable(o_out_data.left_level) && $stable(o_out_data.right_level))

    // Offer only known levels.
    `PWMF_ASSERT_IMP(a_level_known, i_clk, i_rst_n, o_out_valid, !$isunknown(o_out_data))

    // Drop any result and open the input after reset.
    `PWMF_ASSERT_ALW(a_reset_state, i_clk, !i_rst_n, !o_out_valid && o_in_ready)

endmodule

bind pcm_to_pwm_level_formatter_core pwmf_checker u_pwmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ tb/pwm_level_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM level checker
// Follows the register port and both channels of the formatter, works out
// the level pairs each frame transfer should give and compares every level
// transfer, field by field and in order, with the oldest pair still due.
// ----------------------------------------------------------------------------
module pwm_level_checker import pwmf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int REPORT_CAP = 50;

    t_cfg      settings;
    t_out_item level_pairs_due[$];
    int        errors  = 0;
    int        checked = 0;

    function automatic logic [LEVEL_W-1:0] pcm_to_level(
        input logic signed [SAMPLE_W-1:0] sample,
        input logic [VOLUME_W-1:0]        volume
    );
        int prod;
        int offset;
        prod   = int'(sample) * int'(volume);
        // signed division truncates toward zero
        offset = prod / 256 + LEVEL_OFFSET;
        if (offset < 0) begin
            offset = 0;
        end else if (offset > 65535) begin
            offset = 65535;
        end
        return offset[LEVEL_SHIFT +: LEVEL_W];
    endfunction

    task automatic expect_frame_copies(input t_in_item frame);
        logic [LEVEL_W-1:0] lvl_l;
        logic [LEVEL_W-1:0] lvl_r;
        logic [LEVEL_W:0]   lvl_sum;
        int                 shift;
        int                 copies;
        t_out_item          pair;
        lvl_l = pcm_to_level(frame.left_sample, settings.volume_q8);
        lvl_r = settings.source_stereo ?
                pcm_to_level(frame.right_sample, settings.volume_q8) : lvl_l;
        if (!settings.output_stereo) begin
            lvl_sum = {1'b0, lvl_l} + {1'b0, lvl_r};
            lvl_l   = lvl_sum[LEVEL_W:1];
            lvl_r   = lvl_l;
        end
        shift  = (settings.copy_shift > MAX_COPY_SHIFT) ?
                 MAX_COPY_SHIFT : int'(settings.copy_shift);
        copies = 1 << shift;
        for (int k = 0; k < copies; k++) begin
            pair.left_level  = lvl_l;
            pair.right_level = lvl_r;
            pair.last_repeat = (k == copies - 1);
            level_pairs_due.push_back(pair);
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= REPORT_CAP) begin
                $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                         $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            settings.volume_q8     = VOLUME_RESET;
            settings.copy_shift    = REPEAT_RESET;
            settings.source_stereo = 1'b0;
            settings.output_stereo = 1'b1;
            level_pairs_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (level_pairs_due.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_CAP) begin
                        $display("%0t ns: level transfer with none due: expected nothing, actual %0d/%0d last %0b",
                                 $time, i_out_data.left_level, i_out_data.right_level,
                                 i_out_data.last_repeat);
                    end
                end else begin
                    want = level_pairs_due.pop_front();
                    checked++;
                    report_field("left_level", want.left_level, i_out_data.left_level);
                    report_field("right_level", want.right_level, i_out_data.right_level);
                    report_field("last_repeat", want.last_repeat, i_out_data.last_repeat);
                end
            end
            // the frame uses the settings in force before any write at this edge
            if (i_in_valid && i_in_ready) begin
                expect_frame_copies(i_in_data);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VOLUME_Q8:     settings.volume_q8     = i_cfg_data[VOLUME_W-1:0];
                    CFG_COPY_SHIFT:    settings.copy_shift    = i_cfg_data[1:0];
                    CFG_SOURCE_STEREO: settings.source_stereo = i_cfg_data[0];
                    CFG_OUTPUT_STEREO: settings.output_stereo = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_errors  <= errors;
        o_pending <= level_pairs_due.size();
        o_checked <= checked;
    end

endmodule

@@ tb/pcm_to_pwm_level_formatter_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM to PWM level formatter testbench
// Drives directed and random audio frames under a range of register
// settings, with random idling on both channels; a separate checker
// predicts and compares every level pair.
// ----------------------------------------------------------------------------
module pcm_to_pwm_level_formatter_core_test;
    import pwmf_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_FRAMES  = 36;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7FFF;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    int errors;
    int pending;
    int checked;
    int cycles          = 0;
    int frames_sent     = 0;
    int settings_loaded = 0;
    bit idling          = 1'b0;

    pcm_to_pwm_level_formatter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    pwm_level_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d level pairs still due", cycles, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // stall the level channel in random bursts
    initial begin : level_stalls
        int burst;
        forever begin
            @(posedge i_clk);
            if (idling && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 13);
                i_out_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic send_frame(input logic signed [SAMPLE_W-1:0] left_pcm,
                              input logic signed [SAMPLE_W-1:0] right_pcm);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid             <= 1'b1;
        i_in_data.left_sample  <= left_pcm;
        i_in_data.right_sample <= right_pcm;
        // hold until the transfer
        do @(posedge i_clk); while (!o_in_ready);
        frames_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // unused upper data bits carry noise, which the block must drop
    task automatic load_settings(input logic [VOLUME_W-1:0] vol, input logic [1:0] rep,
                                 input logic src_st, input logic out_st);
        write_reg(CFG_VOLUME_Q8, vol);
        write_reg(CFG_COPY_SHIFT, {7'($urandom), rep});
        write_reg(CFG_SOURCE_STEREO, {8'($urandom), src_st});
        write_reg(CFG_OUTPUT_STEREO, {8'($urandom), out_st});
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return PCM_MIN;
            1:       return PCM_MAX;
            2:       return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [VOLUME_W-1:0] pick_volume();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 9'd256;
            2:       return 9'd511;
            default: return 9'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: mono source, two copies per frame
        send_frame(PCM_MIN, PCM_MAX);
        send_frame(PCM_MAX, PCM_MIN);
        send_frame('0, '0);
        send_frame(-16'sd1, 16'sd1);
        wait_drained();

        // gain above unity saturates at both ends
        load_settings(9'd511, 2'd0, 1'b1, 1'b1);
        send_frame(PCM_MIN, PCM_MAX);
        send_frame(PCM_MAX, PCM_MIN);
        send_frame(-16'sd300, 16'sd299);
        wait_drained();

        load_settings('0, 2'd3, 1'b1, 1'b0);
        send_frame(PCM_MAX, PCM_MIN);
        wait_drained();

        // channel average rounds down
        load_settings(9'd256, 2'd2, 1'b1, 1'b0);
        send_frame(PCM_MAX, PCM_MIN);
        send_frame(16'sd100, -16'sd37);
        send_frame(-16'sd1, '0);
        wait_drained();

        // mono source ignores the right sample
        load_settings(9'd300, 2'd0, 1'b0, 1'b0);
        send_frame(-16'sd5, 16'sd12345);
        send_frame(PCM_MAX, PCM_MIN);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // leave some phases, and the last one, free of idling
            idling = (phase != RANDOM_PHASES - 1) && (phase % 3 != 1);
            load_settings(pick_volume(), 2'($urandom), 1'($urandom), 1'($urandom));
            for (int k = 0; k < PHASE_FRAMES; k++) begin
                send_frame(pick_sample(), pick_sample());
            end
            wait_drained();
        end

        $display("%0d frames under %0d register settings gave %0d checked level pairs",
                 frames_sent, settings_loaded + 1, checked);
        if (errors == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
